>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next clock cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, (cond) |=> (cons), msg)

`endif

>>> rtl/hsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_pkg: shared types and helpers for the humidity sensor frame decoder
// Payload structs, byte positions, CRC-8 step and divide-by-65535 helper.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    localparam logic [7:0]  CRC_POLY   = 8'h31;
    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    localparam logic [14:0] TEMP_SPAN  = 15'd17500;
    localparam logic [13:0] HUM_SPAN   = 14'd10000;
    localparam logic [15:0] TEMP_OFS   = 16'd4500;
    localparam logic [15:0] FULL_SCALE = 16'hFFFF;
    localparam int          PROD_W     = 31;
    localparam int          QDEPTH     = 2;
    localparam int          QPTR_W     = $clog2(QDEPTH);
    localparam int          QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } t_pos;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_byte_in;

    typedef struct packed {
        logic signed [14:0] temp_centi_c;
        logic [13:0]        humidity_centi_pct;
        logic [15:0]        raw_temp;
        logic [15:0]        raw_humidity;
        logic               status;
    } t_result;

    // One completed frame, handed from the assembler to the converter.
    typedef struct packed {
        logic [15:0] raw_temp;
        logic [15:0] raw_humidity;
        logic        bad;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // floor(x / 65535): x = q0*65535 + r with q0 = x >> 16, one correction step.
    function automatic logic [15:0] div_full_scale(input logic [PROD_W-1:0] x);
        logic [14:0] q0;
        logic [16:0] r;
        q0 = x[PROD_W-1:16];
        r  = {1'b0, x[15:0]} + {2'b00, q0};
        return (r >= {1'b0, FULL_SCALE}) ? ({1'b0, q0} + 16'd1) : {1'b0, q0};
    endfunction

endpackage

>>> rtl/humidity_sensor_frame_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_top: sensor frame decoder
// Checks six-byte temperature/humidity frames with CRC-8 and converts both
// words to hundredths.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   bytes in | i_push / o_full    | i_in  : rx_byte, frame_start
//   results  | o_empty / i_pop    | o_out : temps, humidity, raw words, status
//
// One byte is taken every cycle while o_full is low; the assembler updates CRC
// and position as each byte is taken. After the sixth byte a result passes the
// queue, the multiply stage and the divide correction into the output register.
// Synchronous active-low reset clears position, CRC to 0xFF and all valid bits.
// o_full rises only while the two-entry frame queue is full under output stall.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  hsfd_pkg::t_byte_in i_in,
    output logic               o_empty,
    input  logic               i_pop,
    output hsfd_pkg::t_result  o_out
);
    import hsfd_pkg::*;

    logic    v_accept;
    logic    v_fpush;
    logic    v_qpop;
    t_frame  v_frame_in;
    t_frame  v_frame_out;
    t_q_stat v_qstat;

    assign o_full   = v_qstat.full;
    assign v_accept = i_push && !o_full;

    hsfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (v_accept),
        .i_in     (i_in),
        .o_push   (v_fpush),
        .o_frame  (v_frame_in)
    );

    hsfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (v_fpush),
        .i_frame (v_frame_in),
        .i_pop   (v_qpop),
        .o_frame (v_frame_out),
        .o_stat  (v_qstat)
    );

    hsfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frame   (v_frame_out),
        .i_q_empty (v_qstat.empty),
        .o_qpop    (v_qpop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_out     (o_out)
    );

endmodule

>>> rtl/hsfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_front: frame assembler
// Tracks the byte position, runs the CRC-8 per word and emits a frame on the
// sixth byte.
// ----------------------------------------------------------------------------
module hsfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  hsfd_pkg::t_byte_in i_in,
    output logic              o_push,
    output hsfd_pkg::t_frame  o_frame
);
    import hsfd_pkg::*;

    t_pos        r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic        r_tfail, n_tfail;

    t_pos        v_pos;
    logic [7:0]  v_crc;
    logic [7:0]  v_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_T_HI;
            r_crc   <= CRC_INIT;
            r_temp  <= '0;
            r_hum   <= '0;
            r_tfail <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_temp  <= n_temp;
            r_hum   <= n_hum;
            r_tfail <= n_tfail;
        end
    end

    always_comb begin
        // restart drops a partial frame
        if (i_in.frame_start || (r_pos > POS_H_CRC)) begin
            v_pos = POS_T_HI;
            v_crc = CRC_INIT;
        end else begin
            v_pos = r_pos;
            v_crc = r_crc;
        end
        v_upd   = crc8_byte(v_crc, i_in.rx_byte);

        n_pos   = r_pos;
        n_crc   = r_crc;
        n_temp  = r_temp;
        n_hum   = r_hum;
        n_tfail = r_tfail;
        o_push  = 1'b0;
        o_frame.raw_temp     = r_temp;
        o_frame.raw_humidity = r_hum;
        o_frame.bad          = r_tfail | (v_crc != i_in.rx_byte);

        if (i_accept) begin
            case (v_pos)
                POS_T_HI: begin
                    n_temp = {i_in.rx_byte, r_temp[7:0]};
                    n_crc  = v_upd;
                    n_pos  = POS_T_LO;
                end
                POS_T_LO: begin
                    n_temp = {r_temp[15:8], i_in.rx_byte};
                    n_crc  = v_upd;
                    n_pos  = POS_T_CRC;
                end
                POS_T_CRC: begin
                    n_tfail = (v_crc != i_in.rx_byte);
                    n_crc   = CRC_INIT;
                    n_pos   = POS_H_HI;
                end
                POS_H_HI: begin
                    n_hum = {i_in.rx_byte, r_hum[7:0]};
                    n_crc = v_upd;
                    n_pos = POS_H_LO;
                end
                POS_H_LO: begin
                    n_hum = {r_hum[15:8], i_in.rx_byte};
                    n_crc = v_upd;
                    n_pos = POS_H_CRC;
                end
                POS_H_CRC: begin
                    o_push = 1'b1;
                    n_crc  = CRC_INIT;
                    n_pos  = POS_T_HI;
                end
                default: begin
                    n_crc = CRC_INIT;
                    n_pos = POS_T_HI;
                end
            endcase
        end
    end

endmodule

>>> rtl/hsfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_queue: short frame queue
// Two-entry FIFO between the assembler and the converter.
// ----------------------------------------------------------------------------
module hsfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hsfd_pkg::t_frame  i_frame,
    input  logic              i_pop,
    output hsfd_pkg::t_frame  o_frame,
    output hsfd_pkg::t_q_stat o_stat
);
    import hsfd_pkg::*;

    `include "assert_macros.svh"

    t_frame            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              v_push, v_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign v_push       = i_push && !o_stat.full;
    assign v_pop        = i_pop && !o_stat.empty;
    assign o_frame      = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (v_push && !v_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (v_pop && !v_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    // depth is a power of two, pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (v_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (v_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QDEPTH), "queue overfilled")
    `ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, v_push && !v_pop, r_count == $past(r_count) + QCNT_W'(1), "push lost")

endmodule

>>> rtl/hsfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_back: fixed-point converter
// Scales both raw words by their span, divides by full scale, subtracts the
// temperature offset and holds the result in the output register.
// ----------------------------------------------------------------------------
module hsfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsfd_pkg::t_frame  i_frame,
    input  logic              i_q_empty,
    output logic              o_qpop,
    input  logic              i_pop,
    output logic              o_empty,
    output hsfd_pkg::t_result o_out
);
    import hsfd_pkg::*;

    `include "assert_macros.svh"

    logic              r_v1, r_v2;
    logic [PROD_W-1:0] r_prod_t, r_prod_h;
    t_frame            r_frame1;
    t_result           r_out;
    logic              v_load1, v_load2;
    logic [15:0]       v_qt, v_qh;
    logic signed [15:0] v_tc;

    assign v_load2 = r_v1 && (!r_v2 || i_pop);
    assign v_load1 = !i_q_empty && (!r_v1 || v_load2);
    assign o_qpop  = v_load1;
    assign o_empty = !r_v2;
    assign o_out   = r_out;

    assign v_qt = div_full_scale(r_prod_t);
    assign v_qh = div_full_scale(r_prod_h);
    assign v_tc = $signed(v_qt) - $signed(TEMP_OFS);

    always_ff @(posedge i_clk) begin
        if (v_load1) begin
            r_prod_t <= PROD_W'(i_frame.raw_temp) * PROD_W'(TEMP_SPAN);
            r_prod_h <= PROD_W'(i_frame.raw_humidity) * PROD_W'(HUM_SPAN);
            r_frame1 <= i_frame;
        end
        if (v_load2) begin
            r_out.temp_centi_c       <= v_tc[14:0];
            r_out.humidity_centi_pct <= v_qh[13:0];
            r_out.raw_temp           <= r_frame1.raw_temp;
            r_out.raw_humidity       <= r_frame1.raw_humidity;
            r_out.status             <= r_frame1.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (v_load1) begin
                r_v1 <= 1'b1;
            end else if (v_load2) begin
                r_v1 <= 1'b0;
            end
            if (v_load2) begin
                r_v2 <= 1'b1;
            end else if (i_pop) begin
                r_v2 <= 1'b0;
            end
        end
    end

    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_v2 && !i_pop, r_v2 && $stable(r_out), "result dropped")
    `ASSERT_NEXT(a_stage_held, i_clk, i_rst_n, r_v1 && !v_load2, r_v1, "product lost")

endmodule

>>> tb/sv/humidity_sensor_frame_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_top_tb: self-checking bench for the decoder
// Feeds sensor bytes through the push/full side and pops decoded frames from
// the empty/pop side. A cycle-free frame predictor tracks position, CRC and the
// assembled words, and queues the result of every sixth byte. A short directed
// table covers the range extremes, CRC failures and restarts. Random frames
// follow, mostly well formed, with corrupted CRCs, truncated frames and noise.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_top_tb;
    import hsfd_pkg::*;

    localparam int   RAND_ITEMS   = 1700;
    localparam int   DIR_N        = 26;
    localparam int   DRAIN_CYCLES = 20;
    localparam int   TIMEOUT_NS   = 2_000_000;
    localparam int   MAX_REPORTS  = 10;
    localparam logic ST_CRC_OK    = 1'b0;
    localparam logic ST_CRC_BAD   = 1'b1;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_push;
    logic     o_full;
    t_byte_in i_in;
    logic     o_empty;
    logic     i_pop;
    t_result  o_out;

    humidity_sensor_frame_decoder_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_in    (i_in),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_out   (o_out)
    );

    // Directed rows; typed rows carry a hand-computed result for their frame.
    typedef struct packed {
        logic [7:0]         rx;
        logic               fs;
        logic               typed;
        logic signed [14:0] t_c;
        logic [13:0]        h_c;
        logic [15:0]        r_t;
        logic [15:0]        r_h;
        logic               st;
    } t_dir_row;

    t_dir_row dir_tbl [DIR_N] = '{
        // all-zero words, opened right after reset without frame_start
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h81, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h81, 1'b0, 1'b1, -15'sd4500, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        // full-scale words, follow-on frame without frame_start
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'hAC, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'hAC, 1'b0, 1'b1, 15'sd13000, 14'd10000, 16'hFFFF, 16'hFFFF, ST_CRC_OK},
        // bad temperature CRC, good humidity CRC
        '{8'hFF, 1'b1, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h81, 1'b0, 1'b1, 15'sd13000, 14'd0, 16'hFFFF, 16'h0000, ST_CRC_BAD},
        // partial frame dropped by a restart, then a bad humidity CRC
        '{8'hBE, 1'b1, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'hEF, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'hBE, 1'b1, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'hEF, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h92, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, 16'h0000, 16'h0000, ST_CRC_OK}
    };

    // Frame predictor state
    t_pos        frm_pos   = POS_T_HI;
    logic [7:0]  crc_run   = CRC_INIT;
    logic [15:0] t_word    = '0;
    logic [15:0] h_word    = '0;
    logic        t_crc_bad = 1'b0;

    t_result frame_results_q [$];

    int n_bytes      = 0;
    int n_frames     = 0;
    int n_crc_bad    = 0;
    int n_restarts   = 0;
    int n_checked    = 0;
    int n_errors     = 0;
    int send_idle_pct  = 21;
    int recv_stall_pct = 72;
    logic realign    = 1'b0;

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc8_next(crc8_next(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // Advance the predictor by one byte; return 1 when the byte closes a frame.
    function automatic logic decode_byte(input t_byte_in b, output t_result r);
        int unsigned tq;
        int unsigned hq;
        r = '0;
        if (b.frame_start) begin
            if (frm_pos != POS_T_HI) n_restarts++;
            frm_pos = POS_T_HI;
            crc_run = CRC_INIT;
        end
        case (frm_pos)
            POS_T_HI: begin
                t_word[15:8] = b.rx_byte;
                crc_run      = crc8_next(crc_run, b.rx_byte);
            end
            POS_T_LO: begin
                t_word[7:0] = b.rx_byte;
                crc_run     = crc8_next(crc_run, b.rx_byte);
            end
            POS_T_CRC: begin
                t_crc_bad = (crc_run != b.rx_byte);
                crc_run   = CRC_INIT;
            end
            POS_H_HI: begin
                h_word[15:8] = b.rx_byte;
                crc_run      = crc8_next(crc_run, b.rx_byte);
            end
            POS_H_LO: begin
                h_word[7:0] = b.rx_byte;
                crc_run     = crc8_next(crc_run, b.rx_byte);
            end
            default: begin
                tq = (32'd17500 * t_word) / 32'd65535;
                hq = (32'd10000 * h_word) / 32'd65535;
                r.temp_centi_c       = 15'(int'(tq) - 4500);
                r.humidity_centi_pct = 14'(hq);
                r.raw_temp           = t_word;
                r.raw_humidity       = h_word;
                r.status = (t_crc_bad || crc_run != b.rx_byte) ? ST_CRC_BAD : ST_CRC_OK;
                frm_pos = POS_T_HI;
                crc_run = CRC_INIT;
                return 1'b1;
            end
        endcase
        frm_pos = t_pos'(frm_pos + 3'd1);
        return 1'b0;
    endfunction

    function automatic logic [15:0] pick_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)  return 16'h0000;
        if (sel < 16) return 16'hFFFF;
        if (sel < 20) return 16'($urandom_range(3));
        if (sel < 24) return 16'($urandom_range(65535, 65532));
        return 16'($urandom_range(65535));
    endfunction

    task automatic report_failure(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Drive one byte, hold it until accepted, then feed the predictor.
    task automatic send_byte(input t_byte_in b, input logic typed, input t_result want);
        t_result r;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_in   <= b;
        do @(posedge i_clk); while (o_full);
        n_bytes++;
        if (decode_byte(b, r)) begin
            n_frames++;
            if (r.status == ST_CRC_BAD) n_crc_bad++;
            frame_results_q.push_back(typed ? want : r);
        end
    endtask

    // Mostly complete frames; some truncated, some plain noise.
    task automatic send_random_frame();
        logic [15:0] tw;
        logic [15:0] hw;
        logic [7:0]  fb [6];
        logic        fs;
        t_byte_in    b;
        int          kind;
        int          n;
        tw = pick_word();
        hw = pick_word();
        fb[0] = tw[15:8];
        fb[1] = tw[7:0];
        fb[2] = word_crc(tw);
        fb[3] = hw[15:8];
        fb[4] = hw[7:0];
        fb[5] = word_crc(hw);
        if ($urandom_range(99) < 12) fb[2] ^= 8'(1 << $urandom_range(7));
        if ($urandom_range(99) < 12) fb[5] ^= 8'(1 << $urandom_range(7));
        fs = (realign && $urandom_range(4) != 0) ? 1'b1 : 1'($urandom_range(1));
        realign = 1'b0;
        kind = $urandom_range(99);
        if (kind < 8) begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++) begin
                b.rx_byte     = 8'($urandom_range(255));
                b.frame_start = ($urandom_range(3) == 0);
                send_byte(b, 1'b0, '0);
            end
            realign = 1'b1;
        end else begin
            n = (kind < 18) ? $urandom_range(5, 1) : 6;
            for (int i = 0; i < n; i++) begin
                b.rx_byte     = fb[i];
                b.frame_start = (i == 0) ? fs : 1'b0;
                send_byte(b, 1'b0, '0);
            end
            if (n < 6) realign = 1'b1;
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (frame_results_q.size() == 0) begin
            report_failure($sformatf("unexpected result T=%0d H=%0d rawT=%h rawH=%h st=%0b",
                got.temp_centi_c, got.humidity_centi_pct, got.raw_temp,
                got.raw_humidity, got.status));
            return;
        end
        want = frame_results_q.pop_front();
        n_checked++;
        if (got.temp_centi_c !== want.temp_centi_c ||
            got.humidity_centi_pct !== want.humidity_centi_pct ||
            got.raw_temp !== want.raw_temp ||
            got.raw_humidity !== want.raw_humidity ||
            got.status !== want.status) begin
            report_failure($sformatf(
                "frame %0d: exp T=%0d H=%0d rawT=%h rawH=%h st=%0b, got T=%0d H=%0d rawT=%h rawH=%h st=%0b",
                n_checked, want.temp_centi_c, want.humidity_centi_pct, want.raw_temp,
                want.raw_humidity, want.status, got.temp_centi_c, got.humidity_centi_pct,
                got.raw_temp, got.raw_humidity, got.status));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d frames still outstanding", frame_results_q.size());
        $display("== FAIL ==");
        $finish;
    end

    // Result side: decide pop on the falling edge, take the transaction on the rising one.
    initial begin
        i_pop = 1'b0;
        forever begin
            @(negedge i_clk);
            i_pop <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) check_result(o_out);
        end
    end

    initial begin
        t_byte_in b;
        t_result  want;
        i_rst_n = 1'b0;
        i_push  = 1'b0;
        i_in    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[i]) begin
            b.rx_byte                = dir_tbl[i].rx;
            b.frame_start            = dir_tbl[i].fs;
            want.temp_centi_c        = dir_tbl[i].t_c;
            want.humidity_centi_pct  = dir_tbl[i].h_c;
            want.raw_temp            = dir_tbl[i].r_t;
            want.raw_humidity        = dir_tbl[i].r_h;
            want.status              = dir_tbl[i].st;
            send_byte(b, dir_tbl[i].typed, want);
        end

        while (n_bytes < DIR_N + RAND_ITEMS) begin
            if (n_bytes < DIR_N + RAND_ITEMS / 3) begin
                send_idle_pct  = 21;
                recv_stall_pct = 72;
            end else if (n_bytes < DIR_N + 2 * RAND_ITEMS / 3) begin
                send_idle_pct  = 72;
                recv_stall_pct = 21;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            send_random_frame();
        end

        @(negedge i_clk);
        i_push <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes with %0d mid-frame restarts", n_bytes, n_restarts);
        $display("Checked %0d of %0d frames, %0d with CRC failures, %0d errors",
                 n_checked, n_frames, n_crc_bad, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
